FILE: rtl/mm3h_pkg.sv
`timescale 1ns / 1ps

package mm3h_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] BYTES_PER_WORD = 3'd4;

   // register index is paddr[2]
   localparam logic CSR_SEED_IDX = 1'b0;

   localparam logic [WORD_W-1:0] MIX_C1 = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] MIX_C2 = 32'h1b873593;
   localparam logic [WORD_W-1:0] MIX_N  = 32'he6546b64;
   localparam logic [WORD_W-1:0] FIN_M1 = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] FIN_M2 = 32'hc2b2ae35;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MIX,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3
   } state_type;

   typedef enum logic [1:0] {
      MUL_SCRAMBLE1,
      MUL_SCRAMBLE2,
      MUL_FINAL1,
      MUL_FINAL2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        mix;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   function automatic logic [WORD_W-1:0] mask_tail(input logic [WORD_W-1:0] word,
                                                   input logic [1:0]        cnt);
      logic [WORD_W-1:0] m;
      case (cnt)
         2'd1:    m = 32'h0000_00ff;
         2'd2:    m = 32'h0000_ffff;
         2'd3:    m = 32'h00ff_ffff;
         default: m = 32'h0000_0000;
      endcase
      return word & m;
   endfunction

endpackage

FILE: rtl/mm3h_datapath.sv
`timescale 1ns / 1ps

module mm3h_datapath
   import mm3h_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WORD_W-1:0]    seed,
   input  logic [WORD_W-1:0]    req_key_word,
   input  logic [COUNT_W-1:0]   req_byte_count,
   input  logic                 req_last_word,
   input  cmd_type              cmd,
   output status_type           status,
   output logic [WORD_W-1:0]    rsp_hash_value,
   output logic                 rsp_length_error
);

   logic [WORD_W-1:0]  word_ff, word_in;
   logic [WORD_W-1:0]  hash_ff, hash_in;
   logic [WORD_W-1:0]  len_ff, len_in;
   logic               err_ff, err_in;
   logic               in_key_ff, in_key_in;
   logic [WORD_W-1:0]  mul_ff, mul_in;
   logic               last_ff, last_in;
   logic               block_ff, block_in;
   logic [COUNT_W-1:0] add_cnt_ff, add_cnt_in;
   logic [WORD_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [COUNT_W-1:0] cnt;
   logic               is_block;
   logic               short_word;
   logic [WORD_W-1:0]  mul_a;
   logic [WORD_W-1:0]  mul_b;
   logic [WORD_W-1:0]  fin_h;
   logic [WORD_W-1:0]  hx;
   logic [WORD_W-1:0]  hr;

   assign cnt        = (req_byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : req_byte_count;
   assign is_block   = !req_last_word || (cnt == BYTES_PER_WORD);
   assign short_word = !req_last_word && (cnt < BYTES_PER_WORD);

   assign fin_h = hash_ff ^ len_ff;
   assign hx    = hash_ff ^ mul_ff;
   assign hr    = {hx[WORD_W-14:0], hx[WORD_W-1:WORD_W-13]};

   always_comb begin
      case (cmd.mul_sel)
         MUL_SCRAMBLE1: begin
            mul_a = word_ff;
            mul_b = MIX_C1;
         end
         MUL_SCRAMBLE2: begin
            mul_a = {mul_ff[WORD_W-16:0], mul_ff[WORD_W-1:WORD_W-15]};
            mul_b = MIX_C2;
         end
         MUL_FINAL1: begin
            mul_a = fin_h ^ (fin_h >> 16);
            mul_b = FIN_M1;
         end
         MUL_FINAL2: begin
            mul_a = mul_ff ^ (mul_ff >> 13);
            mul_b = FIN_M2;
         end
         default: begin
            mul_a = word_ff;
            mul_b = MIX_C1;
         end
      endcase
   end

   always_comb begin
      word_in     = word_ff;
      hash_in     = hash_ff;
      len_in      = len_ff;
      err_in      = err_ff;
      in_key_in   = in_key_ff;
      mul_in      = mul_ff;
      last_in     = last_ff;
      block_in    = block_ff;
      add_cnt_in  = add_cnt_ff;
      rsp_hash_in = rsp_hash_ff;
      rsp_err_in  = rsp_err_ff;

      if (cmd.load) begin
         word_in    = is_block ? req_key_word : mask_tail(req_key_word, cnt[1:0]);
         last_in    = req_last_word;
         block_in   = is_block;
         add_cnt_in = is_block ? BYTES_PER_WORD : cnt;
         in_key_in  = 1'b1;
         if (!in_key_ff) begin
            hash_in = seed;
            len_in  = '0;
            err_in  = short_word;
         end else begin
            err_in  = err_ff | short_word;
         end
      end

      if (cmd.mul_en) begin
         mul_in = mul_a * mul_b;
      end

      if (cmd.mix) begin
         hash_in = block_ff ? (hr + {hr[WORD_W-3:0], 2'b00} + MIX_N) : hx;
         len_in  = len_ff + {{(WORD_W-COUNT_W){1'b0}}, add_cnt_ff};
      end

      if (cmd.out_load) begin
         rsp_hash_in = mul_ff ^ (mul_ff >> 16);
         rsp_err_in  = err_ff;
         in_key_in   = 1'b0;
         len_in      = '0;
         err_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         err_ff    <= 1'b0;
         in_key_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         err_ff    <= err_in;
         in_key_ff <= in_key_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      hash_ff     <= hash_in;
      mul_ff      <= mul_in;
      last_ff     <= last_in;
      block_ff    <= block_in;
      add_cnt_ff  <= add_cnt_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign status.last      = last_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_length_error = rsp_err_ff;

endmodule

FILE: rtl/mm3h_controller.sv
`timescale 1ns / 1ps

module mm3h_controller
   import mm3h_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.mul_en    = 1'b0;
      cmd.mul_sel   = MUL_SCRAMBLE1;
      cmd.mix       = 1'b0;
      cmd.out_load  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCRAMBLE1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SCRAMBLE2;
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = status.last ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FINAL1;
            state_in    = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FINAL2;
            state_in    = ST_FIN3;
         end
         ST_FIN3: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/murmur3_32_stream_hash_core.sv
`timescale 1ns / 1ps

// MurmurHash3 x86_32 over a key streamed as little-endian 32-bit words. Each
// word is accepted, scrambled by two multiplies and mixed into the hash; the
// final word of a key then adds two finalizer multiplies and the output load.
// One shared 32x32 multiplier, used once per cycle, does every multiply. The
// result sits in an output register, so the next word is accepted while a hash
// still waits on rsp_ready. The seed register (address 0) is sampled at the
// first word of each key.

module murmur3_32_stream_hash_core
   import mm3h_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_W-1:0]     req_key_word,
   input  logic [COUNT_W-1:0]    req_byte_count,
   input  logic                  req_last_word,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_hash_value,
   output logic                  rsp_length_error,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              seed_sel;
   cmd_type           cmd;
   status_type        status;

   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[2] == CSR_SEED_IDX);
   assign seed_in    = (csr_psel && csr_penable && csr_pwrite && seed_sel) ?
                       csr_pwdata : seed_ff;
   assign csr_prdata = seed_sel ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mm3h_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mm3h_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .seed             (seed_ff),
      .req_key_word     (req_key_word),
      .req_byte_count   (req_byte_count),
      .req_last_word    (req_last_word),
      .cmd              (cmd),
      .status           (status),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_length_error (rsp_length_error)
   );

endmodule

FILE: bench/tb_murmur3_32_stream_hash_core.sv
`timescale 1ns / 1ps

module tb_murmur3_32_stream_hash_core
   import mm3h_pkg::*;
();

   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned HOLD_OFF   = 250;
   localparam int unsigned SETTLE     = 12;
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR  = {CSR_SEED_IDX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~CSR_SEED_IDX, 2'b00};

   typedef struct {
      logic [WORD_W-1:0]  key_word;
      logic [COUNT_W-1:0] byte_count;
      logic               last_word;
   } key_word_type;

   typedef struct {
      logic [WORD_W-1:0] hash_value;
      logic              length_error;
   } key_hash_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_W-1:0]     req_key_word = '0;
   logic [COUNT_W-1:0]    req_byte_count = '0;
   logic                  req_last_word = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_W-1:0]     rsp_hash_value;
   logic                  rsp_length_error;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   key_word_type word_plan_q[$];
   key_hash_type hash_expect_q[$];

   // predictor state
   logic [WORD_W-1:0] seed_shadow = '0;
   logic [WORD_W-1:0] run_hash = '0;
   logic [WORD_W-1:0] key_len = '0;
   logic              key_err = 1'b0;
   logic              key_open = 1'b0;

   int unsigned words_planned = 0;
   int unsigned words_sent = 0;
   int unsigned hashes_seen = 0;
   int unsigned fail_count = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned idle_cycles = 0;
   logic        send_calm = 1'b0;
   logic        recv_calm = 1'b0;

   murmur3_32_stream_hash_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_word     (req_key_word),
      .req_byte_count   (req_byte_count),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_length_error (rsp_length_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] t;
      t = k * MIX_C1;
      t = rotl(t, 15);
      return t * MIX_C2;
   endfunction

   function automatic logic [WORD_W-1:0] avalanche(input logic [WORD_W-1:0] h);
      logic [WORD_W-1:0] t;
      t = h ^ (h >> 16);
      t = t * FIN_M1;
      t = t ^ (t >> 13);
      t = t * FIN_M2;
      return t ^ (t >> 16);
   endfunction

   // folds one accepted word into the running key hash
   function automatic void absorb_word(input key_word_type w);
      logic [WORD_W-1:0]  h;
      logic [COUNT_W-1:0] n;
      key_hash_type       res;
      n = (w.byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : w.byte_count;
      if (!key_open) begin
         run_hash = seed_shadow;
         key_len  = '0;
         key_err  = 1'b0;
         key_open = 1'b1;
      end
      h = run_hash;
      if (!w.last_word || n == BYTES_PER_WORD) begin
         h = h ^ scramble(w.key_word);
         h = rotl(h, 13) * 5 + MIX_N;
         if (!w.last_word && n < BYTES_PER_WORD)
            key_err = 1'b1;
         key_len = key_len + 4;
      end else begin
         if (n != 0)
            h = h ^ scramble(w.key_word & ~({WORD_W{1'b1}} << (8 * n)));
         key_len = key_len + n;
      end
      run_hash = h;
      if (w.last_word) begin
         res.hash_value   = avalanche(h ^ key_len);
         res.length_error = key_err;
         hash_expect_q.push_back(res);
         key_len  = '0;
         key_err  = 1'b0;
         key_open = 1'b0;
      end
   endfunction

   function automatic int unsigned draw_gap(input logic calm);
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin : req_drv_p
      logic         offer;
      key_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            absorb_word('{req_key_word, req_byte_count, req_last_word});
            words_sent++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (word_plan_q.size() != 0) begin
               nxt = word_plan_q.pop_front();
               req_key_word   <= nxt.key_word;
               req_byte_count <= nxt.byte_count;
               req_last_word  <= nxt.last_word;
               offer = 1'b1;
               send_wait = draw_gap(send_calm);
            end
         end
         req_valid <= offer;
      end
   end

   always @(posedge clock) begin : rsp_mon_p
      key_hash_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hash_expect_q.size() == 0) begin
               $display("%0t: unexpected hash word %h err %b", $time, rsp_hash_value,
                        rsp_length_error);
               fail_count++;
            end else begin
               want = hash_expect_q.pop_front();
               if (rsp_hash_value !== want.hash_value) begin
                  $display("%0t: hash_value expected %h actual %h", $time,
                           want.hash_value, rsp_hash_value);
                  fail_count++;
               end
               if (rsp_length_error !== want.length_error) begin
                  $display("%0t: length_error expected %b actual %b", $time,
                           want.length_error, rsp_length_error);
                  fail_count++;
               end
            end
            hashes_seen++;
            // long back-pressure so the core fills up and stalls its input
            if (hashes_seen == 20 || hashes_seen == 75)
               recv_wait = HOLD_OFF;
            else
               recv_wait = draw_gap(recv_calm);
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_ready <= (recv_wait == 0);
      end
   end

   always @(posedge clock) begin : watchdog_p
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_murmur3_32_stream_hash_core: FAIL");
         $finish;
      end
   end

   task automatic plan_word(input logic [WORD_W-1:0] w, input logic [COUNT_W-1:0] n,
                            input logic last);
      word_plan_q.push_back('{w, n, last});
      words_planned++;
   endtask

   task automatic plan_random_keys(input int unsigned n_words);
      int unsigned planned;
      int unsigned key_words;
      int unsigned r;
      planned = 0;
      while (planned < n_words) begin
         r = $urandom_range(0, 9);
         if (r < 6)
            key_words = $urandom_range(1, 4);
         else if (r < 9)
            key_words = $urandom_range(5, 8);
         else
            key_words = $urandom_range(9, 16);
         for (int i = 0; i < key_words; i++) begin
            if (i == key_words - 1)
               plan_word(rand_word(), COUNT_W'($urandom_range(0, 7)), 1'b1);
            else if ($urandom_range(0, 9) == 0)
               plan_word(rand_word(), COUNT_W'($urandom_range(0, 7)), 1'b0);
            else
               plan_word(rand_word(), BYTES_PER_WORD, 1'b0);
         end
         planned += key_words;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (words_sent != words_planned || hash_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[2] == CSR_SEED_IDX)
         seed_shadow = data;
   endtask

   task automatic csr_check_seed();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== seed_shadow) begin
         $display("%0t: seed readback expected %h actual %h", $time, seed_shadow, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [WORD_W-1:0] seed, input logic s_calm,
                            input logic r_calm);
      csr_write(SEED_ADDR, seed);
      csr_check_seed();
      send_calm = s_calm;
      recv_calm = r_calm;
      plan_random_keys(90);
      wait_drained();
   endtask

   initial begin : stim_p
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_seed();

      // directed keys under the reset seed
      plan_word('0, 3'd0, 1'b1);
      plan_word('1, 3'd1, 1'b1);
      plan_word('1, 3'd2, 1'b1);
      plan_word('1, 3'd3, 1'b1);
      plan_word('1, 3'd4, 1'b1);
      plan_word('0, 3'd4, 1'b1);
      plan_word(32'h1234_5678, 3'd5, 1'b1);
      plan_word(32'h1234_5678, 3'd6, 1'b1);
      plan_word(32'h1234_5678, 3'd7, 1'b1);
      plan_word(32'ha5a5_a5a5, 3'd4, 1'b0);
      plan_word(32'h5a5a_5a5a, 3'd4, 1'b0);
      plan_word(32'hdead_beef, 3'd3, 1'b1);
      // short word inside a key
      plan_word(32'h1122_3344, 3'd2, 1'b0);
      plan_word(32'h5566_7788, 3'd4, 1'b1);
      plan_word('1, 3'd0, 1'b0);
      plan_word('0, 3'd0, 1'b1);
      // oversize counts inside a key count as full words
      plan_word(32'hcafe_f00d, 3'd7, 1'b0);
      plan_word(32'hffff_ff01, 3'd1, 1'b1);
      plan_word(32'h0bad_cafe, 3'd5, 1'b0);
      plan_word(32'h8000_0001, 3'd6, 1'b0);
      plan_word(32'hffff_0102, 3'd2, 1'b1);
      wait_drained();

      // out-of-range register must be ignored
      csr_write(SPARE_ADDR, $urandom);
      run_phase('1, 1'b0, 1'b0);
      run_phase('0, 1'b1, 1'b1);
      run_phase($urandom, 1'b0, 1'b0);
      run_phase(32'h8000_0000, 1'b1, 1'b0);
      run_phase(32'h0000_0001, 1'b0, 1'b1);
      run_phase($urandom, 1'b0, 1'b0);

      if (fail_count == 0)
         $display("tb_murmur3_32_stream_hash_core: PASS");
      else
         $display("tb_murmur3_32_stream_hash_core: FAIL");
      $finish;
   end

endmodule
